[sv/psh_pkg.sv]
package psh_pkg;

    localparam int unsigned DATA_W     = 16;
    localparam int unsigned CHAR_W     = 8;
    localparam int unsigned MOD_W      = DATA_W + 1;
    localparam int unsigned ACC_W      = DATA_W + 2;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned STEP_CNT_W = $clog2(DATA_W);

    localparam logic [DATA_W-1:0] TABLE_SIZE_RST = 16'd11;
    localparam logic [DATA_W-1:0] MULTIPLIER_RST = 16'd31;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TABLE_SIZE = 1'b0,
        REG_MULTIPLIER = 1'b1
    } psh_reg_idx_t;

    // Commands from the sequencer to both modular multiply-add units.
    typedef struct packed {
        logic load;
        logic step;
        logic fin;
    } psh_ctl_t;

    // Operands of one unit: result = (a * b + c) mod M.
    typedef struct packed {
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
        logic [DATA_W-1:0] c;
    } psh_opnd_t;

    // Brings a value below three times the modulus back into range.
    function automatic logic [DATA_W-1:0] mod_fold(input logic [ACC_W-1:0] t,
                                                  input logic [MOD_W-1:0] m);
        logic [ACC_W-1:0] m1;
        logic [ACC_W-1:0] m2;
        m1 = {1'b0, m};
        m2 = {m, 1'b0};
        if (t >= m2) begin
            return DATA_W'(t - m2);
        end else if (t >= m1) begin
            return DATA_W'(t - m1);
        end else begin
            return DATA_W'(t);
        end
    endfunction

endpackage

[sv/polynomial_string_hash_mod_top.sv]
// Polynomial rolling string hash: one key byte per input beat, bucket index per key.
// Between the acceptance of one byte and the acceptance of the next lie two passes of
// 16 bit-serial steps in the pair of modular multiply-add units, plus load, final
// add and commit states. The bucket beat is registered at the commit of the final
// byte; while an earlier bucket is still held, that commit and the input wait for it.
// Synchronous active-low reset: hash 0, power 1, output empty, table_size 11,
// multiplier 31.
module polynomial_string_hash_mod_top import psh_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [CHAR_W-1:0]     s_tdata,   // char_byte[7:0]
    input  logic                  s_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [DATA_W-1:0]     m_tdata,   // bucket_index[15:0]
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [DATA_W-1:0]     cfg_data
);

    logic [DATA_W-1:0] table_size_reg, table_size_next;
    logic [DATA_W-1:0] multiplier_reg, multiplier_next;
    logic [MOD_W-1:0]  modulus;
    logic [DATA_W-1:0] res0;
    logic [DATA_W-1:0] res1;
    psh_ctl_t          ctl;
    psh_opnd_t         opnd0;
    psh_opnd_t         opnd1;

    always_comb begin
        table_size_next = table_size_reg;
        multiplier_next = multiplier_reg;
        if (cfg_we) begin
            unique case (psh_reg_idx_t'(cfg_index))
                REG_TABLE_SIZE: table_size_next = cfg_data;
                REG_MULTIPLIER: multiplier_next = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            table_size_reg <= TABLE_SIZE_RST;
            multiplier_reg <= MULTIPLIER_RST;
        end else begin
            table_size_reg <= table_size_next;
            multiplier_reg <= multiplier_next;
        end
    end

    // A table size of zero stands for 65536 buckets.
    assign modulus = {(table_size_reg == '0), table_size_reg};

    psh_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .multiplier (multiplier_reg),
        .res0       (res0),
        .res1       (res1),
        .ctl        (ctl),
        .opnd0      (opnd0),
        .opnd1      (opnd1)
    );

    psh_modmac u_hash_mac (
        .aclk    (aclk),
        .ctl     (ctl),
        .opnd    (opnd0),
        .modulus (modulus),
        .result  (res0)
    );

    psh_modmac u_power_mac (
        .aclk    (aclk),
        .ctl     (ctl),
        .opnd    (opnd1),
        .modulus (modulus),
        .result  (res1)
    );

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> (!m_tvalid && s_tready))
        else $error("reset did not empty the output or free the input");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken again while a byte is in work");

    a_result_from_work: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result beat appeared without a byte in work");

endmodule

[sv/psh_modmac.sv]
module psh_modmac import psh_pkg::*; (
    input  logic               aclk,
    input  psh_ctl_t           ctl,
    input  psh_opnd_t          opnd,
    input  logic [MOD_W-1:0]   modulus,
    output logic [DATA_W-1:0]  result
);

    logic [DATA_W-1:0] a_reg, a_next;
    logic [DATA_W-1:0] b_reg, b_next;
    logic [DATA_W-1:0] c_reg, c_next;
    logic [DATA_W-1:0] r_reg, r_next;
    logic [ACC_W-1:0]  acc;

    // Horner form, one bit of b per step from the top: r = 2r + b_i * a, folded
    // back below the modulus. The addend c is folded in by a final step.
    always_comb begin
        a_next = a_reg;
        b_next = b_reg;
        c_next = c_reg;
        r_next = r_reg;
        acc    = '0;
        if (ctl.load) begin
            a_next = opnd.a;
            b_next = opnd.b;
            c_next = opnd.c;
            r_next = '0;
        end else if (ctl.step) begin
            acc    = {1'b0, r_reg, 1'b0} + (b_reg[DATA_W-1] ? {2'b00, a_reg} : '0);
            r_next = mod_fold(acc, modulus);
            b_next = {b_reg[DATA_W-2:0], 1'b0};
        end else if (ctl.fin) begin
            acc    = {2'b00, r_reg} + {2'b00, c_reg};
            r_next = mod_fold(acc, modulus);
        end
    end

    always_ff @(posedge aclk) begin
        a_reg <= a_next;
        b_reg <= b_next;
        c_reg <= c_next;
        r_reg <= r_next;
    end

    assign result = r_reg;

endmodule

[sv/psh_ctrl.sv]
module psh_ctrl import psh_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [CHAR_W-1:0]  s_tdata,
    input  logic               s_tlast,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [DATA_W-1:0]  m_tdata,
    input  logic [DATA_W-1:0]  multiplier,
    input  logic [DATA_W-1:0]  res0,
    input  logic [DATA_W-1:0]  res1,
    output psh_ctl_t           ctl,
    output psh_opnd_t          opnd0,
    output psh_opnd_t          opnd1
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RED,
        ST_LOAD,
        ST_MUL,
        ST_FIN,
        ST_COMMIT
    } state_t;

    state_t                  state_reg, state_next;
    logic [STEP_CNT_W-1:0]   cnt_reg, cnt_next;
    logic [DATA_W-1:0]       hash_reg, hash_next;
    logic [DATA_W-1:0]       power_reg, power_next;
    logic [CHAR_W-1:0]       char_reg, char_next;
    logic                    last_reg, last_next;
    logic                    m_tvalid_reg, m_tvalid_next;
    logic [DATA_W-1:0]       m_tdata_reg, m_tdata_next;
    logic                    out_free;
    logic                    cnt_end;

    assign s_tready = (state_reg == ST_IDLE);
    assign out_free = !m_tvalid_reg || m_tready;
    assign cnt_end  = (cnt_reg == STEP_CNT_W'(DATA_W - 1));

    // First pass reduces the held hash and power by the modulus (multiply by one);
    // the second pass forms c * power + hash and power * multiplier.
    always_comb begin
        if (state_reg == ST_IDLE) begin
            opnd0.a = DATA_W'(1);
            opnd0.b = hash_reg;
            opnd0.c = '0;
            opnd1.a = DATA_W'(1);
            opnd1.b = power_reg;
            opnd1.c = '0;
        end else begin
            opnd0.a = res1;
            opnd0.b = {{(DATA_W - CHAR_W){1'b0}}, char_reg};
            opnd0.c = res0;
            opnd1.a = res1;
            opnd1.b = multiplier;
            opnd1.c = '0;
        end
    end

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        hash_next     = hash_reg;
        power_next    = power_reg;
        char_next     = char_reg;
        last_next     = last_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        ctl           = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    ctl.load   = 1'b1;
                    char_next  = s_tdata;
                    last_next  = s_tlast;
                    cnt_next   = '0;
                    state_next = ST_RED;
                end
            end
            ST_RED: begin
                ctl.step = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_end) begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                ctl.load   = 1'b1;
                cnt_next   = '0;
                state_next = ST_MUL;
            end
            ST_MUL: begin
                ctl.step = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_end) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                ctl.fin    = 1'b1;
                state_next = ST_COMMIT;
            end
            ST_COMMIT: begin
                if (!last_reg) begin
                    hash_next  = res0;
                    power_next = res1;
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    // The final byte of a key: hand out the bucket and start afresh.
                    m_tdata_next  = res0;
                    m_tvalid_next = 1'b1;
                    hash_next     = '0;
                    power_next    = DATA_W'(1);
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            hash_reg     <= '0;
            power_reg    <= DATA_W'(1);
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            hash_reg     <= hash_next;
            power_reg    <= power_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        char_reg    <= char_next;
        last_reg    <= last_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

[bench/polynomial_string_hash_mod_top_tb.sv]
module polynomial_string_hash_mod_top_tb;
    import psh_pkg::*;

    localparam int unsigned MAX_GAP      = 13;
    localparam int unsigned ITEM_CYCLES  = 36;
    localparam int unsigned DRAIN_CYCLES = 48;
    localparam int unsigned CYCLE_LIMIT  = 600000;
    localparam int unsigned PHASES       = 10;
    localparam int unsigned PHASE_CHARS  = 112;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [CHAR_W-1:0]    s_tdata;
    logic                 s_tlast;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [DATA_W-1:0]    m_tdata;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DATA_W-1:0]    cfg_data;

    // Predictor state: registers and the running hash of the open key.
    logic [DATA_W-1:0] tbl_size;
    logic [DATA_W-1:0] mult;
    logic [DATA_W-1:0] run_hash;
    logic [DATA_W-1:0] run_power;
    logic [DATA_W-1:0] bucket_q[$];

    int unsigned cycles;
    int unsigned n_chars;
    int unsigned n_keys;
    int unsigned n_buckets;
    int unsigned n_bad;
    int unsigned n_settings;
    bit          quiet_in;
    bit          quiet_out;

    polynomial_string_hash_mod_top u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("polynomial_string_hash_mod_top: mismatch");
            $finish;
        end
    end

    // Folds one byte into the running hash; a zero table size means modulus 65536.
    function automatic void hash_advance(input logic [CHAR_W-1:0] c, input bit last,
                                         output bit emit, output logic [DATA_W-1:0] bucket);
        longint unsigned m;
        longint unsigned h;
        longint unsigned p;
        m = (tbl_size == '0) ? 64'd65536 : 64'(tbl_size);
        h = (64'(run_hash) + 64'(c) * 64'(run_power)) % m;
        p = (64'(run_power) * 64'(mult)) % m;
        emit = last;
        bucket = DATA_W'(h);
        if (last) begin
            run_hash = '0;
            run_power = DATA_W'(1);
        end else begin
            run_hash = DATA_W'(h);
            run_power = DATA_W'(p);
        end
    endfunction

    task automatic write_reg(input psh_reg_idx_t idx, input logic [DATA_W-1:0] val);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        case (idx)
            REG_TABLE_SIZE: tbl_size = val;
            REG_MULTIPLIER: mult = val;
            default: ;
        endcase
        n_settings++;
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    // Lowers the input valid, waits for every bucket to arrive, then lets the
    // block finish any byte that is still in its arithmetic.
    task automatic settle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (bucket_q.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic send_char(input logic [CHAR_W-1:0] c, input bit last);
        int unsigned gap;
        bit          emit;
        logic [DATA_W-1:0] bucket;
        gap = quiet_in ? 0 : $urandom_range(0, MAX_GAP);
        // Half the gaps are counted from the nominal end of the previous byte,
        // so that the valid rises after the ready, or before it where a held bucket stalls the commit.
        if (!quiet_in && $urandom_range(0, 1) == 1) gap += ITEM_CYCLES;
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= c;
        s_tlast <= last;
        do @(posedge aclk); while (!s_tready);
        hash_advance(c, last, emit, bucket);
        n_chars++;
        if (emit) begin
            bucket_q = {bucket_q, bucket};
            n_keys++;
        end
    endtask

    task automatic send_random_key(input int unsigned len);
        for (int unsigned i = 0; i < len; i++) begin
            send_char(CHAR_W'($urandom_range(0, 255)), i == len - 1);
        end
    endtask

    task automatic test_reset_values();
        send_char(8'h00, 1'b1);
        send_char(8'hFF, 1'b1);
        send_char(8'h48, 1'b0);
        send_char(8'h69, 1'b1);
        settle();
    endtask

    task automatic test_table_extremes();
        // Modulus 65536: everything wraps at 16 bits.
        write_reg(REG_TABLE_SIZE, 16'd0);
        write_reg(REG_MULTIPLIER, 16'hFFFF);
        send_char(8'hFF, 1'b0);
        send_char(8'hFF, 1'b0);
        send_char(8'hFF, 1'b1);
        settle();
        write_reg(REG_TABLE_SIZE, 16'hFFFF);
        write_reg(REG_MULTIPLIER, 16'd0);
        send_char(8'h80, 1'b0);
        send_char(8'h7F, 1'b1);
        settle();
        // With a single bucket every key lands in bucket zero.
        write_reg(REG_TABLE_SIZE, 16'd1);
        write_reg(REG_MULTIPLIER, 16'hFFFF);
        send_char(8'hFF, 1'b1);
        send_char(8'h01, 1'b0);
        send_char(8'h02, 1'b1);
        settle();
        write_reg(REG_TABLE_SIZE, 16'd2);
        write_reg(REG_MULTIPLIER, 16'd1);
        send_char(8'h01, 1'b0);
        send_char(8'h01, 1'b0);
        send_char(8'h01, 1'b1);
        settle();
        write_reg(REG_TABLE_SIZE, 16'hFFFF);
        write_reg(REG_MULTIPLIER, 16'hFFFF);
        send_char(8'hAA, 1'b0);
        send_char(8'h55, 1'b1);
        settle();
    endtask

    // The held hash and power survive a register change and are then reduced
    // by the new modulus.
    task automatic test_midkey_write();
        write_reg(REG_TABLE_SIZE, 16'hFFFF);
        write_reg(REG_MULTIPLIER, 16'd257);
        send_char(8'hFF, 1'b0);
        send_char(8'hFF, 1'b0);
        settle();
        write_reg(REG_TABLE_SIZE, 16'd7);
        send_char(8'h10, 1'b0);
        settle();
        write_reg(REG_MULTIPLIER, 16'd0);
        send_char(8'h01, 1'b1);
        settle();
    endtask

    task automatic test_random_keys();
        logic [DATA_W-1:0] ts;
        logic [DATA_W-1:0] mu;
        int unsigned       sent;
        int unsigned       len;
        int unsigned       pick;
        for (int unsigned ph = 0; ph < PHASES; ph++) begin
            case ($urandom_range(0, 7))
                0: ts = 16'd0;
                1: ts = 16'd1;
                2: ts = 16'hFFFF;
                3: ts = DATA_W'($urandom_range(2, 16));
                4: ts = DATA_W'($urandom_range(2, 255));
                default: ts = DATA_W'($urandom_range(0, 65535));
            endcase
            case ($urandom_range(0, 5))
                0: mu = 16'd0;
                1: mu = 16'd1;
                2: mu = 16'hFFFF;
                default: mu = DATA_W'($urandom_range(0, 65535));
            endcase
            write_reg(REG_TABLE_SIZE, ts);
            write_reg(REG_MULTIPLIER, mu);
            quiet_in = (ph % 4 == 3);
            quiet_out = (ph % 4 == 3) || (ph % 5 == 1);
            sent = 0;
            while (sent < PHASE_CHARS) begin
                pick = $urandom_range(0, 19);
                if (pick < 16) len = $urandom_range(1, 8);
                else if (pick < 19) len = $urandom_range(9, 30);
                else len = $urandom_range(31, 80);
                send_random_key(len);
                sent += len;
            end
            settle();
        end
        quiet_in = 1'b0;
        quiet_out = 1'b0;
    endtask

    // Result side: sometimes the ready waits for the valid and then stalls, so
    // that back-pressure meets the bucket beat at any point.
    initial begin : bucket_checker
        bit                hold;
        int unsigned       stall;
        logic [DATA_W-1:0] want;
        @(posedge aresetn);
        forever begin
            hold = !quiet_out && $urandom_range(0, 1) == 1;
            @(negedge aclk);
            if (hold) begin
                m_tready <= 1'b0;
                do @(posedge aclk); while (!m_tvalid);
                stall = $urandom_range(0, MAX_GAP);
                @(negedge aclk);
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            n_buckets++;
            if (bucket_q.size() == 0) begin
                n_bad++;
                if (n_bad <= 10) $display("unexpected bucket beat: got %0d", m_tdata);
            end else begin
                want = bucket_q.pop_front();
                if (m_tdata !== want) begin
                    n_bad++;
                    if (n_bad <= 10) begin
                        $display("bucket_index differs: expected %0d, got %0d", want, m_tdata);
                    end
                end
            end
        end
    end

    initial begin
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        m_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_TABLE_SIZE;
        cfg_data = '0;
        tbl_size = TABLE_SIZE_RST;
        mult = MULTIPLIER_RST;
        run_hash = '0;
        run_power = DATA_W'(1);
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_values();
        test_table_extremes();
        test_midkey_write();
        test_random_keys();
        settle();

        $display("Sent %0d bytes in %0d keys under %0d register writes; %0d buckets checked.",
                 n_chars, n_keys, n_settings, n_buckets);
        $display("Covered modulus 65536, single bucket, zero multiplier and mid-key changes.");
        if (n_bad == 0 && bucket_q.size() == 0) begin
            $display("polynomial_string_hash_mod_top: match");
        end else begin
            $display("polynomial_string_hash_mod_top: mismatch");
        end
        $finish;
    end

endmodule

[files.f]
sv/psh_pkg.sv
sv/psh_modmac.sv
sv/psh_ctrl.sv
sv/polynomial_string_hash_mod_top.sv
bench/polynomial_string_hash_mod_top_tb.sv
